@@ hdl/mfp_interrupt_controller_timers_defines.svh @@
// Assertion macros shared by the MFP interrupt controller and timer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef MFP_INTERRUPT_CONTROLLER_TIMERS_DEFINES_SVH
`define MFP_INTERRUPT_CONTROLLER_TIMERS_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk_i edge outside reset.
`define MFPIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define MFPIT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MFPIT_ASSERT(lbl, prop, msg)
`define MFPIT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/mfpit_pkg.sv @@
// Types, register indexes and constant tables of the MFP interrupt controller and timers.
// No dependencies; used by mfpit_timer, mfpit_core, the top level and the testbench.
package mfpit_pkg;

  localparam int unsigned REG_COUNT = 24;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_ACK   = 3'd2,
    OP_EVENT = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  // Register indexes in the byte window
  localparam logic [4:0] R_IERA  = 5'd3;
  localparam logic [4:0] R_IERB  = 5'd4;
  localparam logic [4:0] R_IPRA  = 5'd5;
  localparam logic [4:0] R_IPRB  = 5'd6;
  localparam logic [4:0] R_ISRA  = 5'd7;
  localparam logic [4:0] R_ISRB  = 5'd8;
  localparam logic [4:0] R_IMRA  = 5'd9;
  localparam logic [4:0] R_IMRB  = 5'd10;
  localparam logic [4:0] R_VR    = 5'd11;
  localparam logic [4:0] R_TACR  = 5'd12;
  localparam logic [4:0] R_TBCR  = 5'd13;
  localparam logic [4:0] R_TCDCR = 5'd14;
  localparam logic [4:0] R_TADR  = 5'd15;
  localparam logic [4:0] R_TBDR  = 5'd16;
  localparam logic [4:0] R_TCDR  = 5'd17;
  localparam logic [4:0] R_TDDR  = 5'd18;
  localparam logic [4:0] R_TSR   = 5'd22;
  localparam logic [4:0] R_UDR   = 5'd23;

  // Highest odd byte offset that still selects a register
  localparam logic [5:0] OFFSET_MAX = 6'd47;

  // Timer source numbers
  localparam logic [3:0] SRC_TA = 4'd2;
  localparam logic [3:0] SRC_TB = 4'd7;
  localparam logic [3:0] SRC_TC = 4'd10;
  localparam logic [3:0] SRC_TD = 4'd11;

  typedef logic [7:0] regs_t [REG_COUNT];

  localparam regs_t RESET_IMAGE = '{
    8'h7b, 8'h06, 8'h00, 8'h18, 8'h3e, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h18, 8'h3e, 8'h40, 8'h08, 8'h01, 8'h77, 8'h01,
    8'h0d, 8'hc8, 8'h14, 8'h00, 8'h88, 8'h01, 8'h81, 8'h00
  };

  localparam logic [8:0] PRESCALE [8] = '{
    9'd1, 9'd10, 9'd25, 9'd40, 9'd125, 9'd160, 9'd250, 9'd500
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] reg_offset;
    logic [7:0] write_data;
    logic [3:0] source_line;
    logic       tick_clocks;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [7:0] vector;
    logic       vector_valid;
  } result_t;

  typedef struct packed {
    logic [8:0] count;
    logic [7:0] data;
    logic       raise;
  } timer_t;

endpackage

@@ hdl/mfpit_if.sv @@
// Valid/ready channel interfaces for the MFP block: operation words in, result words out.
// No dependencies.
interface mfpit_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [5:0] reg_offset;
  logic [7:0] write_data;
  logic [3:0] source_line;
  logic       tick_clocks;

  modport source (output valid, opcode, reg_offset, write_data, source_line, tick_clocks,
                  input ready);
  modport sink (input valid, opcode, reg_offset, write_data, source_line, tick_clocks,
                output ready);
endinterface

interface mfpit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic [7:0] vector;
  logic       vector_valid;

  modport source (output valid, read_data, irq_request, vector, vector_valid,
                  input ready);
  modport sink (input valid, read_data, irq_request, vector, vector_valid,
                output ready);
endinterface

@@ hdl/mfpit_prio.sv @@
// Fixed-priority encoder over the sixteen interrupt sources (source 0 wins).
// Depends on nothing but plain logic.
module mfpit_prio (
  input  logic [15:0] ready_i,
  output logic        found_o,
  output logic [3:0]  src_o
);

  always_comb begin
    found_o = 1'b0;
    src_o   = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (ready_i[i]) begin
        found_o = 1'b1;
        src_o   = 4'(i);
      end
    end
  end

endmodule

@@ hdl/mfpit_timer.sv @@
// One prescaled 8-bit countdown timer step: count, decrement, reload and raise.
// Depends on mfpit_pkg for the prescale table and the timer_t type.
module mfpit_timer (
  input  logic                run_i,
  input  logic [2:0]          sel_i,
  input  logic                clocks_i,
  input  logic [8:0]          count_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          reload_i,
  output mfpit_pkg::timer_t   next_o
);

  logic [8:0] sum;
  logic [8:0] scale;
  logic [7:0] dec;

  always_comb begin
    sum   = count_i + {8'd0, clocks_i};
    scale = mfpit_pkg::PRESCALE[sel_i];
    dec   = data_i - 8'd1;
    next_o.count = count_i;
    next_o.data  = data_i;
    next_o.raise = 1'b0;
    if (run_i) begin
      next_o.count = sum;
      if (sum >= scale) begin
        next_o.count = sum - scale;
        if (dec == 8'd0) begin
          next_o.data  = reload_i;
          next_o.raise = 1'b1;
        end else begin
          next_o.data = dec;
        end
      end
    end
  end

endmodule

@@ hdl/mfpit_core.sv @@
// Register file, timer state and per-operation next-state logic of the MFP block.
// Depends on mfpit_pkg, mfpit_prio, mfpit_timer and the assertion macro header.
`include "mfp_interrupt_controller_timers_defines.svh"

module mfpit_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  mfpit_pkg::item_t    item_i,
  output mfpit_pkg::result_t  res_o
);

  mfpit_pkg::regs_t rf_q, rf_d;
  logic [7:0] reload_q [4];
  logic [7:0] reload_d [4];
  logic [8:0] count_q [4];
  logic [8:0] count_d [4];

  logic [7:0]  rdy_a, rdy_b;
  logic [15:0] src_rdy;
  logic        ack_found;
  logic [3:0]  ack_src;

  mfpit_pkg::timer_t tmr [4];
  logic [3:0] tmr_run;
  logic [2:0] tmr_sel [4];
  logic [7:0] tmr_data [4];
  logic       is_tick;

  assign rdy_a = rf_q[mfpit_pkg::R_IPRA] & rf_q[mfpit_pkg::R_IMRA] & ~rf_q[mfpit_pkg::R_ISRA];
  assign rdy_b = rf_q[mfpit_pkg::R_IPRB] & rf_q[mfpit_pkg::R_IMRB] & ~rf_q[mfpit_pkg::R_ISRB];

  // Source s lives in bit 7-s of its bank
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      src_rdy[i]     = rdy_a[7-i];
      src_rdy[8 + i] = rdy_b[7-i];
    end
  end

  mfpit_prio u_prio (
    .ready_i (src_rdy),
    .found_o (ack_found),
    .src_o   (ack_src)
  );

  assign is_tick = (item_i.opcode == mfpit_pkg::OP_TICK);

  always_comb begin
    tmr_run[0] = is_tick && !rf_q[mfpit_pkg::R_TACR][3] && (rf_q[mfpit_pkg::R_TACR][2:0] != 3'd0);
    tmr_run[1] = is_tick && (rf_q[mfpit_pkg::R_TBCR][2:0] != 3'd0);
    tmr_run[2] = is_tick && (rf_q[mfpit_pkg::R_TCDCR][6:4] != 3'd0);
    tmr_run[3] = is_tick && (rf_q[mfpit_pkg::R_TCDCR][2:0] != 3'd0);
    tmr_sel[0] = rf_q[mfpit_pkg::R_TACR][2:0];
    tmr_sel[1] = rf_q[mfpit_pkg::R_TBCR][2:0];
    tmr_sel[2] = rf_q[mfpit_pkg::R_TCDCR][6:4];
    tmr_sel[3] = rf_q[mfpit_pkg::R_TCDCR][2:0];
    tmr_data[0] = rf_q[mfpit_pkg::R_TADR];
    tmr_data[1] = rf_q[mfpit_pkg::R_TBDR];
    tmr_data[2] = rf_q[mfpit_pkg::R_TCDR];
    tmr_data[3] = rf_q[mfpit_pkg::R_TDDR];
  end

  for (genvar t = 0; t < 4; t++) begin : g_tmr
    mfpit_timer u_timer (
      .run_i    (tmr_run[t]),
      .sel_i    (tmr_sel[t]),
      .clocks_i (item_i.tick_clocks),
      .count_i  (count_q[t]),
      .data_i   (tmr_data[t]),
      .reload_i (reload_q[t]),
      .next_o   (tmr[t])
    );
  end

  always_comb begin
    logic [4:0]  r;
    logic [4:0]  rel;
    logic [15:0] raise;
    logic [7:0]  raise_a, raise_b;
    logic [2:0]  pos;

    rf_d     = rf_q;
    reload_d = reload_q;
    count_d  = count_q;
    raise    = 16'd0;
    r        = item_i.reg_offset[5:1];
    rel      = r - mfpit_pkg::R_TADR;
    pos      = ~ack_src[2:0];
    res_o    = '0;

    if (go_i) begin
      case (item_i.opcode)
        mfpit_pkg::OP_READ: begin
          if (item_i.reg_offset > mfpit_pkg::OFFSET_MAX) begin
            res_o.read_data = 8'h00;
          end else if (item_i.reg_offset[0]) begin
            res_o.read_data = rf_q[r];
          end else begin
            res_o.read_data = 8'hff;
          end
        end
        mfpit_pkg::OP_WRITE: begin
          if (item_i.reg_offset <= mfpit_pkg::OFFSET_MAX && item_i.reg_offset[0]) begin
            case (r)
              mfpit_pkg::R_IERA, mfpit_pkg::R_IERB: begin
                rf_d[r]         = item_i.write_data;
                rf_d[r + 5'd2]  = rf_q[r + 5'd2] & item_i.write_data;
              end
              mfpit_pkg::R_IPRA, mfpit_pkg::R_IPRB,
              mfpit_pkg::R_ISRA, mfpit_pkg::R_ISRB: begin
                rf_d[r] = rf_q[r] & item_i.write_data;
              end
              mfpit_pkg::R_TSR: begin
                rf_d[r] = item_i.write_data | 8'h80;
              end
              mfpit_pkg::R_TADR, mfpit_pkg::R_TBDR,
              mfpit_pkg::R_TCDR, mfpit_pkg::R_TDDR: begin
                rf_d[r]              = item_i.write_data;
                reload_d[rel[1:0]]   = item_i.write_data;
              end
              mfpit_pkg::R_UDR: begin
              end
              default: begin
                rf_d[r] = item_i.write_data;
              end
            endcase
          end
        end
        mfpit_pkg::OP_ACK: begin
          if (ack_found) begin
            if (ack_src[3]) begin
              rf_d[mfpit_pkg::R_IPRB][pos] = 1'b0;
              if (rf_q[mfpit_pkg::R_VR][3]) rf_d[mfpit_pkg::R_ISRB][pos] = 1'b1;
            end else begin
              rf_d[mfpit_pkg::R_IPRA][pos] = 1'b0;
              if (rf_q[mfpit_pkg::R_VR][3]) rf_d[mfpit_pkg::R_ISRA][pos] = 1'b1;
            end
            res_o.vector       = {rf_q[mfpit_pkg::R_VR][7:4], ~ack_src};
            res_o.vector_valid = 1'b1;
          end else begin
            res_o.vector = 8'hff;
          end
        end
        mfpit_pkg::OP_EVENT: begin
          raise[item_i.source_line] = 1'b1;
        end
        mfpit_pkg::OP_TICK: begin
          for (int t = 0; t < 4; t++) count_d[t] = tmr[t].count;
          rf_d[mfpit_pkg::R_TADR] = tmr[0].data;
          rf_d[mfpit_pkg::R_TBDR] = tmr[1].data;
          rf_d[mfpit_pkg::R_TCDR] = tmr[2].data;
          rf_d[mfpit_pkg::R_TDDR] = tmr[3].data;
          raise[mfpit_pkg::SRC_TA] = tmr[0].raise;
          raise[mfpit_pkg::SRC_TB] = tmr[1].raise;
          raise[mfpit_pkg::SRC_TC] = tmr[2].raise;
          raise[mfpit_pkg::SRC_TD] = tmr[3].raise;
        end
        default: begin
        end
      endcase
    end

    // Latch raised sources into pending, gated by their enables
    for (int i = 0; i < 8; i++) begin
      raise_a[7-i] = raise[i];
      raise_b[7-i] = raise[8 + i];
    end
    rf_d[mfpit_pkg::R_IPRA] = rf_d[mfpit_pkg::R_IPRA] | (rf_q[mfpit_pkg::R_IERA] & raise_a);
    rf_d[mfpit_pkg::R_IPRB] = rf_d[mfpit_pkg::R_IPRB] | (rf_q[mfpit_pkg::R_IERB] & raise_b);

    res_o.irq_request =
      |(rf_d[mfpit_pkg::R_IPRA] & rf_d[mfpit_pkg::R_IMRA] & ~rf_d[mfpit_pkg::R_ISRA]) ||
      |(rf_d[mfpit_pkg::R_IPRB] & rf_d[mfpit_pkg::R_IMRB] & ~rf_d[mfpit_pkg::R_ISRB]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q     <= mfpit_pkg::RESET_IMAGE;
      reload_q <= '{default: 8'd0};
      count_q  <= '{default: 9'd0};
    end else begin
      rf_q     <= rf_d;
      reload_q <= reload_d;
      count_q  <= count_d;
    end
  end

  `MFPIT_ASSERT_NEVER(a_tsr_bit7, !rf_q[mfpit_pkg::R_TSR][7], "TSR bit 7 cleared")
  `MFPIT_ASSERT(a_idle_hold, !go_i |=> $stable(rf_q[mfpit_pkg::R_IERA]) && $stable(rf_q[mfpit_pkg::R_VR]), "registers changed without an operation")

endmodule

@@ hdl/mfp_interrupt_controller_timers.sv @@
// Top level of the MFP block: input word register, operation core and result word register.
// Depends on mfpit_pkg, mfpit_if, mfpit_core and the assertion macro header.
//
// Multi-function peripheral with a 16-source prioritized interrupt controller and four
// prescaled 8-bit countdown timers behind a 24-register byte window. Each input word is
// one operation (read, write, interrupt acknowledge, source event or clock tick) and
// produces exactly one result word. An accepted word sits in the input register until
// it advances; then its whole effect on the register file, the timer reloads and the
// prescale counts is computed by one pass of short logic and committed together with the
// result word into the output register. One word is taken every cycle for as long as
// the result side keeps up: the output register decouples the two sides, so a new word
// is accepted while a finished result still waits. Reset loads the register file from
// its initialization image and clears the reloads and prescale counts; there is no
// clearing pass.
`include "mfp_interrupt_controller_timers_defines.svh"

module mfp_interrupt_controller_timers (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfpit_in_if.sink      in_i,
  mfpit_out_if.source   out_o
);

  // Input register: holds the word that the core works on next
  logic                s0_valid_q, s0_valid_d;
  mfpit_pkg::item_t    s0_item_q;
  mfpit_pkg::item_t    in_item;

  // Output register: holds a finished result until the sink takes it
  logic                out_valid_q, out_valid_d;
  mfpit_pkg::result_t  out_res_q;
  mfpit_pkg::result_t  core_res;

  logic                advance;
  logic                accept;

  assign in_item.opcode      = in_i.opcode;
  assign in_item.reg_offset  = in_i.reg_offset;
  assign in_item.write_data  = in_i.write_data;
  assign in_item.source_line = in_i.source_line;
  assign in_item.tick_clocks = in_i.tick_clocks;

  // Advance the held word into the output register when that register is free or draining
  assign advance    = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (advance) begin
      s0_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // The core commits state only on the cycle the word advances
  mfpit_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .item_i (s0_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_item_q <= in_item;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = out_res_q.read_data;
  assign out_o.irq_request  = out_res_q.irq_request;
  assign out_o.vector       = out_res_q.vector;
  assign out_o.vector_valid = out_res_q.vector_valid;

  `MFPIT_ASSERT(a_no_overwrite, s0_valid_q && !advance |-> !in_i.ready, "held word would be overwritten")
  `MFPIT_ASSERT(a_advance_lands, advance |=> out_valid_q, "advanced word lost before output")
  `MFPIT_ASSERT(a_vec_no_read, out_valid_q && out_res_q.vector_valid |-> out_res_q.read_data == 8'h00, "vector and read data both set")

endmodule

@@ test/mfp_interrupt_controller_timers_tb.sv @@
// Self-checking testbench for mfp_interrupt_controller_timers: directed table, then random words.
// Depends on mfpit_pkg and the mfpit_in_if / mfpit_out_if channel interfaces of the RTL.
module mfp_interrupt_controller_timers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfpit_pkg::*;

  // Registers that the package does not name
  localparam logic [4:0] REG_GPIP = 5'd0;
  localparam logic [4:0] REG_RSR  = 5'd21;

  // Offsets that select no register
  localparam logic [5:0] OFF_EVEN = 6'd0;
  localparam logic [5:0] OFF_TOP  = 6'd63;

  // Opcodes that do nothing
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam int RANDOM_WORDS = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;

  typedef struct {
    item_t   w;
    bit      fixed;
    result_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  mfpit_in_if  word_in ();
  mfpit_out_if word_out ();

  mfp_interrupt_controller_timers dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in),
    .out_o  (word_out)
  );

  // Mirror of the block's state
  regs_t      mirror_regs;
  logic [7:0] mirror_reload [4];
  logic [8:0] mirror_count [4];

  // Results still owed by the block, oldest first
  result_t expected_q[$];

  // Typed-in expectation that travels with the word being offered
  bit      fixed_now;
  result_t fixed_want;

  // Idling is switched off for the tail of the run
  bit steady;

  int errors;
  int words_taken;
  int results_checked;
  int vectors_found;
  int timer_fires;
  int cycle_count;

  row_t plan[$];

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run; the bound covers every word waiting out the longest gaps
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sources of one bank that are pending, unmasked and not in service
  function automatic logic [7:0] pending_mask(logic bank);
    return mirror_regs[R_IPRA + bank] & mirror_regs[R_IMRA + bank]
           & ~mirror_regs[R_ISRA + bank];
  endfunction

  // Set a pending bit, but only for an enabled source
  function automatic void raise_line(logic [3:0] src);
    logic       bank;
    logic [7:0] bit_m;
    bank  = src[3];
    bit_m = 8'h80 >> src[2:0];
    if ((mirror_regs[R_IERA + bank] & bit_m) != 8'h00)
      mirror_regs[R_IPRA + bank] |= bit_m;
  endfunction

  // Advance one timer by the tick's clocks: one decrement at most, reload on zero
  function automatic void step_timer(int t, logic [2:0] sel, logic [4:0] dreg,
                                     logic [3:0] src, logic clocks);
    mirror_count[t] = mirror_count[t] + clocks;
    if (mirror_count[t] >= PRESCALE[sel]) begin
      mirror_count[t]   = mirror_count[t] - PRESCALE[sel];
      mirror_regs[dreg] = mirror_regs[dreg] - 8'd1;
      if (mirror_regs[dreg] == 8'h00) begin
        mirror_regs[dreg] = mirror_reload[t];
        raise_line(src);
        timer_fires++;
      end
    end
  endfunction

  // Apply one operation word to the mirror and return the result word it yields
  function automatic result_t apply_word(item_t w);
    result_t    r;
    logic [4:0] idx;
    logic [7:0] d;
    logic [7:0] ready_b;
    logic [7:0] bit_m;
    logic [7:0] tacr, tbcr, tcdcr;
    bit         found;
    r     = '0;
    idx   = w.reg_offset[5:1];
    d     = w.write_data;
    found = 1'b0;
    case (w.opcode)
      OP_READ: begin
        if (w.reg_offset > OFFSET_MAX) r.read_data = 8'h00;
        else if (w.reg_offset[0]) r.read_data = mirror_regs[idx];
        else r.read_data = 8'hff;
      end
      OP_WRITE: begin
        // Even offsets and offsets past the window write nothing
        if (w.reg_offset <= OFFSET_MAX && w.reg_offset[0]) begin
          case (idx)
            R_IERA, R_IERB: begin
              // Disabling a source also drops its pending bit
              mirror_regs[idx]     = d;
              mirror_regs[idx + 2] = mirror_regs[idx + 2] & d;
            end
            R_IPRA, R_IPRB, R_ISRA, R_ISRB: mirror_regs[idx] = mirror_regs[idx] & d;
            R_TSR: mirror_regs[idx] = d | 8'h80;
            R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
              mirror_regs[idx]          = d;
              mirror_reload[idx - R_TADR] = d;
            end
            R_UDR: ;
            default: mirror_regs[idx] = d;
          endcase
        end
      end
      OP_ACK: begin
        r.vector = 8'hff;
        for (int bank = 0; bank < 2; bank++) begin
          ready_b = pending_mask(bank[0]);
          for (int b = 0; b < 8; b++) begin
            bit_m = 8'h80 >> b;
            if (!found && (ready_b & bit_m) != 8'h00) begin
              mirror_regs[R_IPRA + bank] &= ~bit_m;
              if (mirror_regs[R_VR][3]) mirror_regs[R_ISRA + bank] |= bit_m;
              r.vector       = 8'((bank != 0 ? 7 : 15) - b) | (mirror_regs[R_VR] & 8'hf0);
              r.vector_valid = 1'b1;
              found          = 1'b1;
            end
          end
        end
      end
      OP_EVENT: raise_line(w.source_line);
      OP_TICK: begin
        tacr  = mirror_regs[R_TACR];
        tbcr  = mirror_regs[R_TBCR];
        tcdcr = mirror_regs[R_TCDCR];
        // Timer A stays stopped while its event-count bit is set
        if (!tacr[3] && tacr[2:0] != 3'd0)
          step_timer(0, tacr[2:0], R_TADR, SRC_TA, w.tick_clocks);
        if (tbcr[2:0] != 3'd0) step_timer(1, tbcr[2:0], R_TBDR, SRC_TB, w.tick_clocks);
        if (tcdcr[6:4] != 3'd0) step_timer(2, tcdcr[6:4], R_TCDR, SRC_TC, w.tick_clocks);
        if (tcdcr[2:0] != 3'd0) step_timer(3, tcdcr[2:0], R_TDDR, SRC_TD, w.tick_clocks);
      end
      default: ;
    endcase
    r.irq_request = |(pending_mask(1'b0) | pending_mask(1'b1));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Compare each delivered result word with the oldest expectation, then
  // predict the word taken at this edge. A result cannot stem from the word
  // taken at the same edge, so the order of the two halves is safe.
  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    item_t   w;
    if (rst_ni) begin
      if (word_out.valid && word_out.ready) begin
        got.read_data    = word_out.read_data;
        got.irq_request  = word_out.irq_request;
        got.vector       = word_out.vector;
        got.vector_valid = word_out.vector_valid;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result word %p with none expected", got));
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (got.read_data !== want.read_data)
            flag_error($sformatf("read_data %h, want %h", got.read_data, want.read_data));
          if (got.irq_request !== want.irq_request)
            flag_error($sformatf("irq_request %b, want %b", got.irq_request,
                                 want.irq_request));
          if (got.vector !== want.vector)
            flag_error($sformatf("vector %h, want %h", got.vector, want.vector));
          if (got.vector_valid !== want.vector_valid)
            flag_error($sformatf("vector_valid %b, want %b", got.vector_valid,
                                 want.vector_valid));
        end
      end
      if (word_in.valid && word_in.ready) begin
        w.opcode      = word_in.opcode;
        w.reg_offset  = word_in.reg_offset;
        w.write_data  = word_in.write_data;
        w.source_line = word_in.source_line;
        w.tick_clocks = word_in.tick_clocks;
        want = apply_word(w);
        if (want.vector_valid) vectors_found++;
        // A typed-in row overrides the prediction but the mirror still advances
        expected_q.push_back(fixed_now ? fixed_want : want);
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t mk(logic [2:0] op, logic [5:0] off, logic [7:0] d,
                               logic [3:0] src, logic clocks);
    item_t w;
    w.opcode      = op;
    w.reg_offset  = off;
    w.write_data  = d;
    w.source_line = src;
    w.tick_clocks = clocks;
    return w;
  endfunction

  function automatic result_t res(logic [7:0] rd, logic irq, logic [7:0] vec, logic vv);
    result_t r;
    r.read_data    = rd;
    r.irq_request  = irq;
    r.vector       = vec;
    r.vector_valid = vv;
    return r;
  endfunction

  // Odd byte offset of a register
  function automatic logic [5:0] off_of(logic [4:0] r);
    return {r, 1'b1};
  endfunction

  task automatic add_row(item_t w, bit fixed, result_t want);
    row_t row;
    row.w     = w;
    row.fixed = fixed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // Prescale selector: mostly the short ones so timers fire often
  function automatic logic [2:0] pick_sel();
    if ($urandom_range(0, 9) < 7) return 3'($urandom_range(1, 2));
    return 3'($urandom_range(0, 7));
  endfunction

  // Random word with every field random, then shaped towards one operation
  function automatic item_t random_word();
    item_t      w;
    int         pick;
    logic [4:0] r;
    w.opcode      = 3'($urandom);
    w.reg_offset  = 6'($urandom);
    w.write_data  = 8'($urandom);
    w.source_line = 4'($urandom);
    w.tick_clocks = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      w.opcode = OP_READ;
      if ($urandom_range(0, 4) != 0) w.reg_offset = off_of(5'($urandom_range(0, 23)));
    end else if (pick < 42) begin
      w.opcode = OP_WRITE;
      // Keep a tenth of the writes on raw offsets, even and out of window included
      if ($urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) r = 5'($urandom_range(R_IERA, R_VR));
        else if (pick < 85) r = 5'($urandom_range(R_TACR, R_TDDR));
        else r = 5'($urandom_range(0, 23));
        w.reg_offset = off_of(r);
        case (r)
          R_TACR:
            if ($urandom_range(0, 4) != 0) w.write_data = {4'($urandom), 1'b0, pick_sel()};
          R_TBCR:
            if ($urandom_range(0, 4) != 0) w.write_data = {5'($urandom), pick_sel()};
          R_TCDCR:
            if ($urandom_range(0, 4) != 0)
              w.write_data = {1'($urandom), pick_sel(), 1'($urandom), pick_sel()};
          R_TADR, R_TBDR, R_TCDR, R_TDDR:
            if ($urandom_range(0, 9) < 7) w.write_data = 8'($urandom_range(1, 4));
          R_IERA, R_IERB, R_IMRA, R_IMRB:
            if ($urandom_range(0, 9) < 3) w.write_data = 8'hff;
          // Clear in-service bits often so acknowledges keep finding sources
          R_ISRA, R_ISRB:
            if ($urandom_range(0, 1) != 0) w.write_data = 8'h00;
          default: ;
        endcase
      end
    end else if (pick < 58) begin
      w.opcode = OP_ACK;
    end else if (pick < 74) begin
      w.opcode = OP_EVENT;
    end else if (pick < 95) begin
      w.opcode      = OP_TICK;
      w.tick_clocks = ($urandom_range(0, 6) != 0);
    end else begin
      w.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return w;
  endfunction

  // Sender gap before a word: mostly none, sometimes a burst
  function automatic int pick_gap();
    if (steady || $urandom_range(0, 6) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(item_t w, bit fixed, result_t want, int gap);
    if (gap > 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_in.valid       <= 1'b1;
    word_in.opcode      <= w.opcode;
    word_in.reg_offset  <= w.reg_offset;
    word_in.write_data  <= w.write_data;
    word_in.source_line <= w.source_line;
    word_in.tick_clocks <= w.tick_clocks;
    fixed_now           <= fixed;
    fixed_want          <= want;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result word has come back
  task automatic hold_until_drained();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready in random stall bursts, steady at the end
  // ---------------------------------------------------------------------------
  initial begin
    word_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        word_out.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      word_out.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, directed table, random words, end of run
  // ---------------------------------------------------------------------------
  initial begin
    errors          = 0;
    words_taken     = 0;
    results_checked = 0;
    vectors_found   = 0;
    timer_fires     = 0;
    steady          = 1'b0;

    // Seed the mirror with the block's reset state
    mirror_regs = RESET_IMAGE;
    for (int t = 0; t < 4; t++) begin
      mirror_reload[t] = 8'h00;
      mirror_count[t]  = 9'd0;
    end

    rst_ni                 = 1'b0;
    word_in.valid         <= 1'b0;
    word_in.opcode        <= OP_READ;
    word_in.reg_offset    <= '0;
    word_in.write_data    <= '0;
    word_in.source_line   <= '0;
    word_in.tick_clocks   <= 1'b0;
    fixed_now             <= 1'b0;
    fixed_want            <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads straight after reset, odd and even offsets, window edges
    add_row(mk(OP_READ, off_of(REG_GPIP), 8'h00, 4'h0, 1'b0), 1, res(8'h7b, 0, 8'h00, 0));
    add_row(mk(OP_READ, OFF_EVEN, 8'h00, 4'h0, 1'b0), 1, res(8'hff, 0, 8'h00, 0));
    add_row(mk(OP_READ, OFF_TOP, 8'hff, 4'hf, 1'b1), 1, res(8'h00, 0, 8'h00, 0));
    add_row(mk(OP_READ, off_of(R_VR), 8'h00, 4'h0, 1'b0), 1, res(8'h40, 0, 8'h00, 0));
    add_row(mk(OP_READ, off_of(REG_RSR), 8'h00, 4'h0, 1'b0), 1, res(8'h01, 0, 8'h00, 0));
    add_row(mk(OP_READ, off_of(R_UDR), 8'h00, 4'h0, 1'b0), 1, res(8'h00, 0, 8'h00, 0));
    // Acknowledge with nothing pending gives the default vector
    add_row(mk(OP_ACK, 6'h00, 8'h00, 4'h0, 1'b0), 1, res(8'h00, 0, 8'hff, 0));
    // Unused opcode with every field at its top
    add_row(mk(OP_UNUSED_HI, OFF_TOP, 8'hff, 4'hf, 1'b1), 1, res(8'h00, 0, 8'h00, 0));
    // Enable and unmask everything, VR with software end-of-interrupt
    add_row(mk(OP_WRITE, off_of(R_IERA), 8'hff, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_IERB), 8'hff, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_IMRA), 8'hff, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_IMRB), 8'hff, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_VR), 8'h58, 4'h0, 1'b0), 0, '0);
    // Highest, lowest and a middle source, then acknowledge past the last
    add_row(mk(OP_EVENT, 6'h00, 8'h00, 4'hf, 1'b0), 0, '0);
    add_row(mk(OP_EVENT, 6'h00, 8'h00, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_EVENT, 6'h00, 8'h00, 4'h4, 1'b0), 0, '0);
    for (int k = 0; k < 4; k++) add_row(mk(OP_ACK, 6'h00, 8'h00, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_ISRA), 8'h00, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_TSR), 8'h00, 4'h0, 1'b0), 0, '0);
    // Timer A at prescale selector 1 from data 1, then a counted and an uncounted tick
    add_row(mk(OP_WRITE, off_of(R_TADR), 8'h01, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_TACR), 8'h01, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_TICK, 6'h00, 8'h00, 4'h0, 1'b1), 0, '0);
    add_row(mk(OP_TICK, 6'h00, 8'h00, 4'h0, 1'b0), 0, '0);
    // Event on a disabled source, then writes that land nowhere
    add_row(mk(OP_WRITE, off_of(R_IERB), 8'h00, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_EVENT, 6'h00, 8'h00, 4'hc, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, off_of(R_UDR), 8'h5a, 4'h0, 1'b0), 0, '0);
    add_row(mk(OP_WRITE, {R_VR, 1'b0}, 8'h00, 4'h0, 1'b0), 0, '0);

    foreach (plan[i]) send_word(plan[i].w, plan[i].fixed, plan[i].want, pick_gap());

    // Let the directed words drain before the random part starts
    hold_until_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) hold_until_drained();
      steady = (i >= RANDOM_WORDS * 17 / 20);
      send_word(random_word(), 1'b0, '0, pick_gap());
    end

    hold_until_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("Run covered %0d words, %0d results checked, %0d vectors delivered,",
             words_taken, results_checked, vectors_found);
    $display("%0d timer underflows and %0d mismatches.", timer_fires, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
